/* rtl/efbt_pkg.sv */
// Shared types for the expiring flow block table: operation codes, the
// broadcast item, the carry that walks the cell chain and the install command.
// No dependencies.
package efbt_pkg;

  localparam int unsigned IdxMaxW = 8;
  localparam int unsigned CntMaxW = 9;

  typedef enum logic [1:0] {
    OpStart  = 2'd0,
    OpAppend = 2'd1,
    OpLookup = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    StIdle    = 2'd0,
    StWalk    = 2'd1,
    StInstall = 2'd2,
    StFin     = 2'd3
  } state_e;

  localparam logic [1:0] StatusAdded    = 2'd0;
  localparam logic [1:0] StatusPresent  = 2'd1;
  localparam logic [1:0] StatusRejected = 2'd2;
  localparam logic [1:0] StatusAppended = 2'd3;

  localparam logic [2:0] ModeServer = 3'd1;
  localparam logic [2:0] ModeClient = 3'd2;

  typedef struct packed {
    op_e                op;
    logic [31:0]        now;
    logic [2:0]         mode;
    logic [31:0]        cip;
    logic [31:0]        sid;
    logic [31:0]        ep_ip;
    logic [15:0]        ep_port;
    logic [IdxMaxW-1:0] bslot;
    logic               discard;
    logic [31:0]        sip;
    logic [31:0]        dip;
    logic [15:0]        dport;
  } item_t;

  typedef struct packed {
    logic               valid;
    logic               found;
    logic [IdxMaxW-1:0] slot;
    logic               have_idle;
    logic [IdxMaxW-1:0] idle;
    logic [CntMaxW-1:0] cleared;
    logic               appended;
    logic               bslot_live;
  } carry_t;

  typedef struct packed {
    logic               valid;
    logic [IdxMaxW-1:0] slot;
    logic [2:0]         mode;
    logic [31:0]        cip;
    logic [31:0]        sid;
    logic [31:0]        end_t;
    logic [31:0]        ep_ip;
    logic [15:0]        ep_port;
  } install_t;

endpackage

/* rtl/efbt_cell.sv */
// One table slot of the expiring flow block table: rule fields and endpoints.
// Acts on the carry from its left neighbour and hands it on through a register.
// Depends on efbt_pkg.
module efbt_cell #(
  parameter int unsigned IDX           = 0,
  parameter int unsigned MAX_ENDPOINTS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  efbt_pkg::item_t    item_i,
  input  efbt_pkg::install_t inst_i,
  input  efbt_pkg::carry_t   carry_i,
  output efbt_pkg::carry_t   carry_o
);

  localparam int unsigned EW = $clog2(MAX_ENDPOINTS + 1);
  localparam int unsigned AW = (MAX_ENDPOINTS > 1) ? $clog2(MAX_ENDPOINTS) : 1;

  logic [1:0]    mode_q;
  logic [31:0]   client_q;
  logic [31:0]   sid_q;
  logic [31:0]   end_q;
  logic [EW-1:0] cnt_q;
  logic [31:0]   ep_addr_q [MAX_ENDPOINTS];
  logic [15:0]   ep_port_q [MAX_ENDPOINTS];

  efbt_pkg::carry_t carry_d, carry_q;
  logic live, expired, ep_hit, key_hit, clr, app, inst_me;
  logic [2:0] mode_x;

  assign mode_x  = {1'b0, mode_q};
  assign live    = (mode_q != 2'd0);
  assign expired = (end_q <= item_i.now);
  assign inst_me = inst_i.valid && (inst_i.slot == efbt_pkg::IdxMaxW'(IDX));
  assign key_hit = (mode_x == item_i.mode) && (sid_q == item_i.sid) &&
                   ((item_i.mode == efbt_pkg::ModeServer) || (client_q == item_i.cip));

  always_comb begin
    ep_hit = 1'b0;
    for (int j = 0; j < MAX_ENDPOINTS; j++) begin
      if ((j < int'(cnt_q)) && (ep_addr_q[j] == item_i.dip) &&
          ((ep_port_q[j] == 16'd0) || (ep_port_q[j] == item_i.dport))) begin
        ep_hit = 1'b1;
      end
    end
  end

  always_comb begin
    carry_d = carry_i;
    clr     = 1'b0;
    app     = 1'b0;
    if (carry_i.valid) begin
      case (item_i.op)
        efbt_pkg::OpStart: begin
          if (live && expired) begin
            clr             = 1'b1;
            carry_d.cleared = carry_i.cleared + efbt_pkg::CntMaxW'(1);
            if (!carry_i.have_idle) begin
              carry_d.have_idle = 1'b1;
              carry_d.idle      = efbt_pkg::IdxMaxW'(IDX);
            end
          end else if (live) begin
            if (key_hit && !carry_i.found) begin
              carry_d.found = 1'b1;
              carry_d.slot  = efbt_pkg::IdxMaxW'(IDX);
            end
          end else if (!carry_i.have_idle) begin
            carry_d.have_idle = 1'b1;
            carry_d.idle      = efbt_pkg::IdxMaxW'(IDX);
          end
        end
        efbt_pkg::OpAppend: begin
          if ((item_i.bslot == efbt_pkg::IdxMaxW'(IDX)) && !item_i.discard && live) begin
            carry_d.bslot_live = 1'b1;
            carry_d.slot       = efbt_pkg::IdxMaxW'(IDX);
            if (int'(cnt_q) < MAX_ENDPOINTS) begin
              app              = 1'b1;
              carry_d.appended = 1'b1;
            end
          end
        end
        efbt_pkg::OpLookup: begin
          if (!carry_i.found && live) begin
            if (!expired) begin
              if (((mode_x == efbt_pkg::ModeServer) ||
                   ((mode_x == efbt_pkg::ModeClient) && (client_q == item_i.sip))) &&
                  ep_hit) begin
                carry_d.found = 1'b1;
                carry_d.slot  = efbt_pkg::IdxMaxW'(IDX);
              end
            end else begin
              clr             = 1'b1;
              carry_d.cleared = carry_i.cleared + efbt_pkg::CntMaxW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
      mode_q  <= 2'd0;
      cnt_q   <= '0;
    end else begin
      carry_q <= carry_d;
      if (inst_me) begin
        mode_q <= inst_i.mode[1:0];
        cnt_q  <= EW'(1);
      end else if (clr) begin
        mode_q <= 2'd0;
        cnt_q  <= '0;
      end else if (app) begin
        cnt_q <= cnt_q + EW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (inst_me) begin
      client_q     <= (inst_i.mode == efbt_pkg::ModeClient) ? inst_i.cip : 32'd0;
      sid_q        <= inst_i.sid;
      end_q        <= inst_i.end_t;
      ep_addr_q[0] <= inst_i.ep_ip;
      ep_port_q[0] <= inst_i.ep_port;
    end else if (app) begin
      ep_addr_q[cnt_q[AW-1:0]] <= item_i.ep_ip;
      ep_port_q[cnt_q[AW-1:0]] <= item_i.ep_port;
    end
  end

  assign carry_o = carry_q;

endmodule

/* rtl/expiring_flow_block_table.sv */
// Expiring flow block table. Each item walks a chain of TABLE_ENTRIES slot
// cells, one slot per cycle, with all endpoints of a slot compared at once.
// The walk is followed by an install state when a new rule is added, then a
// finish state that loads the registered result; input stall stays high from
// acceptance until then, so a new item is taken only after the last one's
// result is loaded. A result held by output stall keeps the next one back.
// Depends on efbt_pkg and efbt_cell.
module expiring_flow_block_table #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned MAX_ENDPOINTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [31:0] now_i,
  input  logic [1:0]  mode_i,
  input  logic [31:0] client_ip_i,
  input  logic [31:0] server_id_i,
  input  logic [30:0] duration_i,
  input  logic [31:0] endpoint_ip_i,
  input  logic [15:0] endpoint_port_i,
  input  logic        last_endpoint_i,
  input  logic [31:0] src_ip_i,
  input  logic [31:0] dst_ip_i,
  input  logic [15:0] dst_port_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic [1:0]  add_status_o,
  output logic        hit_o,
  output logic [3:0]  entry_index_o,
  output logic [4:0]  active_rules_o
);

  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned IW = efbt_pkg::IdxMaxW;

  efbt_pkg::state_e   state_q, state_d;
  efbt_pkg::item_t    item_q;
  efbt_pkg::install_t inst_q, inst;
  efbt_pkg::carry_t   chain [TABLE_ENTRIES+1];

  logic          start_q, last_q, building_q, building_d, discard_q, discard_d;
  logic [IW-1:0] bslot_q, bslot_d;
  logic [CW-1:0] active_q, active_d;
  logic          out_valid_q, load_out, take_in, done, do_inst;
  logic          hit_q, hit_d;
  logic [1:0]    status_q, status_d;
  logic [IW-1:0] slot_q, slot_d;
  logic [32:0]   end_sum;

  assign take_in = in_valid_i && !in_stall_o;
  assign done    = chain[TABLE_ENTRIES].valid && (state_q == efbt_pkg::StWalk);
  assign end_sum = {1'b0, now_i} + {2'b00, duration_i};

  assign chain[0] = '{valid: start_q, default: '0};

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    efbt_cell #(
      .IDX          (g),
      .MAX_ENDPOINTS(MAX_ENDPOINTS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .item_i (item_q),
      .inst_i (inst),
      .carry_i(chain[g]),
      .carry_o(chain[g+1])
    );
  end

  always_comb begin
    inst       = inst_q;
    inst.valid = (state_q == efbt_pkg::StInstall);
  end

  always_comb begin
    state_d    = state_q;
    building_d = building_q;
    discard_d  = discard_q;
    bslot_d    = bslot_q;
    active_d   = active_q;
    status_d   = status_q;
    hit_d      = hit_q;
    slot_d     = slot_q;
    do_inst    = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      efbt_pkg::StIdle: begin
        if (take_in) state_d = efbt_pkg::StWalk;
      end
      efbt_pkg::StWalk: begin
        if (done) begin
          hit_d    = 1'b0;
          status_d = efbt_pkg::StatusAdded;
          slot_d   = '0;
          active_d = active_q - CW'(chain[TABLE_ENTRIES].cleared);
          state_d  = efbt_pkg::StFin;
          case (item_q.op)
            efbt_pkg::OpStart: begin
              if (chain[TABLE_ENTRIES].found) begin
                status_d = efbt_pkg::StatusPresent;
                slot_d   = chain[TABLE_ENTRIES].slot;
              end else if (!chain[TABLE_ENTRIES].have_idle || item_q.mode > 3'd2) begin
                status_d = efbt_pkg::StatusRejected;
              end else begin
                slot_d   = chain[TABLE_ENTRIES].idle;
                active_d = active_q - CW'(chain[TABLE_ENTRIES].cleared) + CW'(1);
                do_inst  = 1'b1;
                state_d  = efbt_pkg::StInstall;
              end
              if (last_q) begin
                building_d = 1'b0;
                discard_d  = 1'b0;
              end else begin
                building_d = 1'b1;
                bslot_d    = slot_d;
                discard_d  = (status_d != efbt_pkg::StatusAdded);
              end
            end
            efbt_pkg::OpAppend: begin
              status_d = chain[TABLE_ENTRIES].appended ? efbt_pkg::StatusAppended
                                                       : efbt_pkg::StatusRejected;
              slot_d   = chain[TABLE_ENTRIES].bslot_live ? chain[TABLE_ENTRIES].slot : '0;
              if (last_q) begin
                building_d = 1'b0;
                discard_d  = 1'b0;
              end
            end
            efbt_pkg::OpLookup: begin
              hit_d  = chain[TABLE_ENTRIES].found;
              slot_d = chain[TABLE_ENTRIES].found ? chain[TABLE_ENTRIES].slot : '0;
            end
            default: begin
            end
          endcase
        end
      end
      efbt_pkg::StInstall: begin
        state_d = efbt_pkg::StFin;
      end
      efbt_pkg::StFin: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = efbt_pkg::StIdle;
        end
      end
      default: state_d = efbt_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= efbt_pkg::StIdle;
      start_q     <= 1'b0;
      building_q  <= 1'b0;
      discard_q   <= 1'b0;
      bslot_q     <= '0;
      active_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      start_q    <= take_in;
      building_q <= building_d;
      discard_q  <= discard_d;
      bslot_q    <= bslot_d;
      active_q   <= active_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    hit_q    <= hit_d;
    slot_q   <= slot_d;
    if (take_in) begin
      last_q         <= last_endpoint_i;
      item_q.op      <= cmd_i ? efbt_pkg::OpLookup
                              : (building_q ? efbt_pkg::OpAppend : efbt_pkg::OpStart);
      item_q.now     <= now_i;
      item_q.mode    <= {1'b0, mode_i} + 3'd1;
      item_q.cip     <= client_ip_i;
      item_q.sid     <= server_id_i;
      item_q.ep_ip   <= endpoint_ip_i;
      item_q.ep_port <= endpoint_port_i;
      item_q.bslot   <= bslot_q;
      item_q.discard <= discard_q;
      item_q.sip     <= src_ip_i;
      item_q.dip     <= dst_ip_i;
      item_q.dport   <= dst_port_i;
      inst_q.cip     <= client_ip_i;
      inst_q.sid     <= server_id_i;
      inst_q.mode    <= {1'b0, mode_i} + 3'd1;
      inst_q.end_t   <= end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];
      inst_q.ep_ip   <= endpoint_ip_i;
      inst_q.ep_port <= endpoint_port_i;
    end
    if (do_inst) begin
      inst_q.slot <= slot_d;
    end
    inst_q.valid <= 1'b0;
    if (load_out) begin
      result_kind_o  <= (item_q.op == efbt_pkg::OpLookup);
      add_status_o   <= status_q;
      hit_o          <= hit_q;
      entry_index_o  <= slot_q[3:0];
      active_rules_o <= 5'(active_q);
    end
  end

  assign in_stall_o  = (state_q != efbt_pkg::StIdle);
  assign out_valid_o = out_valid_q;

endmodule

/* rtl/efbt_checker.sv */
// Port-level checks for the expiring flow block table, bound to the top level.
// Depends on expiring_flow_block_table only through the bind.
module efbt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       result_kind_o,
  input logic [1:0] add_status_o,
  input logic       hit_o,
  input logic [3:0] entry_index_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item taken while previous item still in the chain");

  a_add_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !result_kind_o |-> !hit_o)
    else $error("add answer shows a hit");

  a_lookup_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o |-> (add_status_o == 2'd0) &&
                                     (hit_o || (entry_index_o == 4'd0)))
    else $error("lookup answer fields inconsistent");

endmodule

bind expiring_flow_block_table efbt_checker u_efbt_checker (.*);

/* dv/expiring_flow_block_table_tb.sv */
// Self-checking bench for the expiring flow block table: directed and random
// add and lookup items against an in-bench table predictor, random idling.
// Depends on efbt_pkg and the expiring_flow_block_table RTL.
`timescale 1ns / 1ps

module expiring_flow_block_table_tb;

  localparam int unsigned Slots = 16;
  localparam int unsigned EpMax = 8;
  localparam logic CmdAdd = 1'b0;
  localparam logic CmdLookup = 1'b1;
  localparam logic [1:0] ReqServer = 2'd0;
  localparam logic [1:0] ReqClient = 2'd1;

  typedef struct packed {
    logic        cmd;
    logic [31:0] now;
    logic [1:0]  mode;
    logic [31:0] cip;
    logic [31:0] sid;
    logic [30:0] dur;
    logic [31:0] ep_ip;
    logic [15:0] ep_port;
    logic        last;
    logic [31:0] sip;
    logic [31:0] dip;
    logic [15:0] dport;
  } req_t;

  typedef struct packed {
    logic       kind;
    logic [1:0] status;
    logic       hit;
    logic [3:0] idx;
    logic [4:0] active;
  } verdict_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  req_t cur;
  logic result_kind_o, hit_o;
  logic [1:0] add_status_o;
  logic [3:0] entry_index_o;
  logic [4:0] active_rules_o;

  expiring_flow_block_table dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .cmd_i(cur.cmd), .now_i(cur.now), .mode_i(cur.mode), .client_ip_i(cur.cip),
    .server_id_i(cur.sid), .duration_i(cur.dur), .endpoint_ip_i(cur.ep_ip),
    .endpoint_port_i(cur.ep_port), .last_endpoint_i(cur.last), .src_ip_i(cur.sip),
    .dst_ip_i(cur.dip), .dst_port_i(cur.dport),
    .out_valid_o, .out_stall_i, .result_kind_o, .add_status_o, .hit_o,
    .entry_index_o, .active_rules_o
  );

  // predictor state
  logic [2:0]  t_mode [Slots];
  logic [31:0] t_cip [Slots], t_sid [Slots], t_end [Slots];
  int unsigned t_cnt [Slots];
  logic [31:0] t_ep_ip [Slots][EpMax];
  logic [15:0] t_ep_port [Slots][EpMax];
  int unsigned live_rules;
  bit          in_build, build_drop;
  int unsigned build_at;

  req_t     pending_q [$];
  verdict_t awaited_q [$];
  int unsigned mismatches, verdicts_seen, hits_seen, outstanding;
  bit driver_hold;
  logic in_taken;

  function automatic void drop_rule(int unsigned s);
    if (t_mode[s] != 0) begin
      t_mode[s] = 0;
      t_cnt[s] = 0;
      if (live_rules > 0) live_rules--;
    end
  endfunction

  function automatic bit ep_match(int unsigned s, logic [31:0] dip, logic [15:0] dp);
    for (int unsigned j = 0; j < t_cnt[s]; j++)
      if (t_ep_ip[s][j] == dip && (t_ep_port[s][j] == 0 || t_ep_port[s][j] == dp))
        return 1;
    return 0;
  endfunction

  function automatic verdict_t predict_block(req_t r);
    verdict_t v;
    logic [2:0] m;
    logic [32:0] sum;
    int unsigned idle;
    bit have_idle, done;
    v = '0;
    v.kind = r.cmd;
    if (r.cmd == CmdAdd && !in_build) begin
      m = {1'b0, r.mode} + 3'd1;
      have_idle = 0;
      idle = 0;
      done = 0;
      for (int unsigned s = 0; s < Slots; s++)
        if (t_mode[s] != 0 && t_end[s] <= r.now) drop_rule(s);
      for (int unsigned s = 0; s < Slots && !done; s++) begin
        if (t_mode[s] != 0) begin
          if (t_mode[s] == m && t_sid[s] == r.sid &&
              (m == efbt_pkg::ModeServer || t_cip[s] == r.cip)) begin
            v.status = efbt_pkg::StatusPresent;
            v.idx = 4'(s);
            done = 1;
          end
        end else if (!have_idle) begin
          have_idle = 1;
          idle = s;
        end
      end
      if (!done) begin
        if (!have_idle || m > efbt_pkg::ModeClient) begin
          v.status = efbt_pkg::StatusRejected;
        end else begin
          sum = {1'b0, r.now} + {2'b0, r.dur};
          t_mode[idle] = m;
          t_cip[idle] = (m == efbt_pkg::ModeClient) ? r.cip : 32'd0;
          t_sid[idle] = r.sid;
          t_end[idle] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          t_ep_ip[idle][0] = r.ep_ip;
          t_ep_port[idle][0] = r.ep_port;
          t_cnt[idle] = 1;
          live_rules++;
          v.status = efbt_pkg::StatusAdded;
          v.idx = 4'(idle);
        end
      end
      build_drop = (v.status != efbt_pkg::StatusAdded);
      in_build = !r.last;
      build_at = v.idx;
      if (r.last) build_drop = 0;
    end else if (r.cmd == CmdAdd) begin
      v.status = efbt_pkg::StatusRejected;
      if (!build_drop && t_mode[build_at] != 0) begin
        v.idx = 4'(build_at);
        if (t_cnt[build_at] < EpMax) begin
          t_ep_ip[build_at][t_cnt[build_at]] = r.ep_ip;
          t_ep_port[build_at][t_cnt[build_at]] = r.ep_port;
          t_cnt[build_at]++;
          v.status = efbt_pkg::StatusAppended;
        end
      end
      if (r.last) begin
        in_build = 0;
        build_drop = 0;
      end
    end else begin
      done = 0;
      for (int unsigned s = 0; s < Slots && !done; s++) begin
        if (t_mode[s] == 0) continue;
        if (t_end[s] > r.now) begin
          if ((t_mode[s] == efbt_pkg::ModeServer ||
               (t_mode[s] == efbt_pkg::ModeClient && t_cip[s] == r.sip))
              && ep_match(s, r.dip, r.dport)) begin
            v.hit = 1;
            v.idx = 4'(s);
            done = 1;
          end
        end else begin
          drop_rule(s);
        end
      end
    end
    v.active = live_rules[4:0];
    return v;
  endfunction

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // driver
  int unsigned send_gap;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 0;
      cur <= '0;
      send_gap <= 0;
    end else if (!in_valid_i || in_taken) begin
      if (send_gap > 0) begin
        in_valid_i <= 0;
        send_gap <= send_gap - 1;
      end else if (pending_q.size() > 0 && !driver_hold) begin
        in_valid_i <= 1;
        cur <= pending_q.pop_front();
        outstanding++;
        send_gap <= $urandom_range(0, 9);
      end else begin
        in_valid_i <= 0;
      end
    end
  end

  // input acceptance feeds the predictor
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) awaited_q.push_back(predict_block(cur));
  end

  // receiver stall
  int unsigned recv_gap;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 0;
      recv_gap <= 0;
    end else if (recv_gap > 0) begin
      out_stall_i <= 1;
      recv_gap <= recv_gap - 1;
    end else begin
      out_stall_i <= 0;
      if (out_valid_o && !out_stall_i)
        recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    verdict_t got, exp_v;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{result_kind_o, add_status_o, hit_o, entry_index_o, active_rules_o};
      verdicts_seen++;
      if (outstanding > 0) outstanding--;
      if (hit_o) hits_seen++;
      if (awaited_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        exp_v = awaited_q.pop_front();
        if (got !== exp_v) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", exp_v, got);
        end
      end
    end
  end

  function automatic req_t rand_req();
    req_t r;
    r = '0;
    r.cmd = 1'($urandom_range(0, 1));
    r.now = $urandom;
    r.mode = 2'($urandom_range(0, 3));
    r.cip = $urandom;
    r.sid = $urandom;
    r.dur = 31'($urandom >> 1);
    r.ep_ip = $urandom;
    r.ep_port = 16'($urandom);
    r.last = 1'($urandom_range(0, 1));
    r.sip = $urandom;
    r.dip = $urandom;
    r.dport = 16'($urandom);
    return r;
  endfunction

  logic [31:0] clock_s;
  logic [31:0] pool_ip [4];

  function automatic req_t add_req(logic [1:0] md, bit last);
    req_t r;
    r = rand_req();
    r.cmd = CmdAdd;
    r.now = clock_s;
    r.mode = md;
    r.cip = pool_ip[$urandom_range(0, 3)];
    r.sid = $urandom_range(0, 5);
    r.dur = ($urandom_range(0, 19) == 0) ? 31'h7FFF_FFFF : 31'($urandom_range(1, 60));
    r.ep_ip = pool_ip[$urandom_range(0, 3)];
    r.ep_port = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(79, 82));
    r.last = last;
    return r;
  endfunction

  function automatic req_t look_req();
    req_t r;
    r = rand_req();
    r.cmd = CmdLookup;
    r.now = clock_s;
    r.sip = pool_ip[$urandom_range(0, 3)];
    r.dip = pool_ip[$urandom_range(0, 3)];
    r.dport = 16'($urandom_range(79, 82));
    return r;
  endfunction

  initial begin
    req_t r;
    int unsigned n;
    for (int unsigned s = 0; s < Slots; s++) begin
      t_mode[s] = 0;
      t_cnt[s] = 0;
    end
    live_rules = 0;
    in_build = 0;
    build_drop = 0;
    build_at = 0;
    mismatches = 0;
    verdicts_seen = 0;
    hits_seen = 0;
    outstanding = 0;
    driver_hold = 0;
    clock_s = 100;
    foreach (pool_ip[i]) pool_ip[i] = $urandom;
    rst_ni = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;

    // directed: bad modes, fill table, overflow, present, endpoints, expiry
    for (int m = 2; m < 4; m++) pending_q.push_back(add_req(2'(m), 1));
    for (int unsigned s = 0; s < Slots + 1; s++) begin
      r = add_req(s[0] ? ReqClient : ReqServer, 1);
      r.sid = 100 + s;
      r.dur = (s == 3) ? 31'h7FFF_FFFF : 31'(5 + s);
      pending_q.push_back(r);
    end
    r = add_req(ReqServer, 1);
    r.sid = 100;
    pending_q.push_back(r);
    r = add_req(ReqClient, 0);
    r.now = 32'hFFFF_FFF0;
    r.sid = 32'hFFFF_FFFF;
    r.ep_ip = 32'hFFFF_FFFF;
    r.ep_port = 16'hFFFF;
    r.dur = 31'h7FFF_FFFF;
    pending_q.push_back(r);
    for (int k = 0; k < 9; k++) begin
      r = add_req(ReqServer, k == 8);
      r.cmd = CmdAdd;
      pending_q.push_back(r);
    end
    r = look_req();
    r.now = 32'hFFFF_FFFF;
    pending_q.push_back(r);
    r = look_req();
    r.now = 0;
    r.dip = 0;
    r.dport = 0;
    pending_q.push_back(r);
    wait (pending_q.size() == 0 && outstanding == 0);
    driver_hold = 1;

    // random: mostly well-formed builds and lookups at an advancing clock
    n = 0;
    driver_hold = 0;
    while (n < 1250) begin
      clock_s += $urandom_range(0, 3);
      case ($urandom_range(0, 9))
        0: r = rand_req();
        1, 2, 3: begin
          int unsigned eps;
          eps = $urandom_range(0, 9);
          pending_q.push_back(add_req($urandom_range(0, 7) == 0 ? 2'($urandom_range(2, 3))
                                      : 2'($urandom_range(0, 1)), eps == 0));
          for (int unsigned e = 1; e <= eps; e++) begin
            r = add_req(ReqServer, e == eps);
            if (e != eps) pending_q.push_back(r);
            n++;
          end
          if (eps == 0) r = look_req();
        end
        default: r = look_req();
      endcase
      pending_q.push_back(r);
      n++;
      if (n > 600 && n < 620 && !driver_hold) begin
        wait (pending_q.size() == 0 && outstanding == 0);
        driver_hold = 0;
      end
    end
    wait (pending_q.size() == 0 && outstanding == 0);
    repeat (40) @(posedge clk_i);
    $display("%0d results checked, %0d lookup hits, %0d rules held at the end",
             verdicts_seen, hits_seen, live_rules);
    if (mismatches == 0 && awaited_q.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* files.f */
rtl/efbt_pkg.sv
rtl/efbt_cell.sv
rtl/expiring_flow_block_table.sv
rtl/efbt_checker.sv
dv/expiring_flow_block_table_tb.sv
